>>> hw/rtl/tep_pkg.sv
`default_nettype none

package tep_pkg;

	// default sizing
	localparam int unsigned QUEUE_DEPTH_DEF  = 64;
	localparam int unsigned PAYLOAD_BITS_DEF = 32;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_BEYOND   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// class that is checked against the end time
	localparam logic [2:0] CLASS_CALLBACK = 3'd5;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] event_time;
		logic [2:0]  event_class;
		logic [31:0] event_payload;
		logic [31:0] target_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] assigned_id;
		logic [63:0] out_time;
		logic [2:0]  out_class;
		logic [31:0] out_payload;
		logic [31:0] out_id;
		logic [63:0] now_time;
		logic [6:0]  occupancy;
	} rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/timed_event_priority_queue.sv
// Timed event priority queue for a discrete-event simulator.
// Request channel: req_valid / req_stall carry one request (insert, pop least,
// delete by id). Response channel: rsp_valid / rsp_stall carry exactly one
// response per request, in request order.
// cfg_we / cfg_wdata write the end time; write it only while the queue is idle.
// Every event lives in one single-port memory of QUEUE_DEPTH entries; a
// request that needs the store walks it one entry per cycle through a single
// compare unit (lowest free slot, least key, or first id match).
// Insert, pop and delete walk the whole memory (S_SCAN, then S_FIN, then
// S_DONE) before rsp_valid rises; an insert refused as full or beyond end, a
// pop or delete on an empty store and an unused code go straight to S_DONE.
// One request is in work at a time; req_stall is high from the acceptance
// until the response is written into the output register, so no new request
// is taken before the last one is through.
// A finished response waits in the output register while rsp_stall is high;
// the next request is taken meanwhile, and its response is held back until
// the register is free.
// Reset (arst_n low) empties the queue, clears the sequence id, the current
// time and the end time and drops a waiting response. The memory is not cleared.
`default_nettype none

module timed_event_priority_queue #(
	parameter int unsigned QUEUE_DEPTH  = tep_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned PAYLOAD_BITS = tep_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [63:0]   cfg_wdata,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire tep_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output tep_pkg::rsp_t      rsp
);
	import tep_pkg::*;

	localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned PW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
	localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	typedef struct packed {
		logic [63:0]   ev_time;
		logic [2:0]    ev_class;
		logic [31:0]   ev_id;
		logic [PW-1:0] ev_payload;
	} entry_t;

	entry_t mem [QUEUE_DEPTH];

	logic [1:0]             state_q;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [CW-1:0]          cnt_q;
	logic [31:0]            seq_q;
	logic [63:0]            cur_q;
	logic [63:0]            end_q;
	req_t                   req_q;
	logic                   beyond_q;
	logic [IW-1:0]          idx_q;
	logic                   found_q;
	logic [IW-1:0]          best_idx_q;
	entry_t                 best_q;
	logic                   scan_s1;
	logic                   vld_s1;
	logic [IW-1:0]          idx_s1;
	entry_t                 rd_s1;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic   req_acc;
	logic   beyond_d;
	logic   take;
	logic   fire;
	logic   ins_ok;
	logic   pop_ok;
	logic   del_ok;
	logic   adv_time;
	entry_t wr_entry;
	rsp_t   rsp_d;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// end check of a callback insert
	assign beyond_d = (req.event_class == CLASS_CALLBACK) && (end_q != 64'd0) &&
		(req.event_time > end_q);

	// shared compare unit, one memory entry per cycle
	always_comb begin
		case (req_q.req_type)
			REQ_INSERT: take = !found_q && !vld_s1;
			REQ_POP:    take = vld_s1 && (!found_q ||
				({rd_s1.ev_time, rd_s1.ev_class, rd_s1.ev_id} <
				 {best_q.ev_time, best_q.ev_class, best_q.ev_id}));
			REQ_DELETE: take = !found_q && vld_s1 && (rd_s1.ev_id == req_q.target_id);
			default:    take = 1'b0;
		endcase
	end

	// completion of the request
	assign fire     = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
	assign ins_ok   = (req_q.req_type == REQ_INSERT) && !beyond_q && found_q;
	assign pop_ok   = (req_q.req_type == REQ_POP) && found_q;
	assign del_ok   = (req_q.req_type == REQ_DELETE) && found_q &&
		(best_q.ev_time > cur_q) && (best_q.ev_time < end_q);
	assign adv_time = pop_ok && (best_q.ev_time > cur_q);

	assign wr_entry.ev_time    = req_q.event_time;
	assign wr_entry.ev_class   = req_q.event_class;
	assign wr_entry.ev_id      = seq_q;
	assign wr_entry.ev_payload = req_q.event_payload[PW-1:0];

	// response word
	always_comb begin
		rsp_d          = '0;
		rsp_d.status   = ST_NOTFOUND;
		rsp_d.now_time = adv_time ? best_q.ev_time : cur_q;
		rsp_d.occupancy = 7'(cnt_q);
		case (req_q.req_type)
			REQ_INSERT: begin
				if (beyond_q) begin
					rsp_d.status = ST_BEYOND;
				end else if (found_q) begin
					rsp_d.status      = ST_OK;
					rsp_d.assigned_id = seq_q;
					rsp_d.occupancy   = 7'(cnt_q + 1'b1);
				end else begin
					rsp_d.status = ST_FULL;
				end
			end
			REQ_POP: begin
				if (found_q) begin
					rsp_d.status      = ST_OK;
					rsp_d.out_time    = best_q.ev_time;
					rsp_d.out_class   = best_q.ev_class;
					rsp_d.out_payload = 32'(best_q.ev_payload);
					rsp_d.out_id      = best_q.ev_id;
					rsp_d.occupancy   = 7'(cnt_q - 1'b1);
				end else begin
					rsp_d.status = ST_EMPTY;
				end
			end
			REQ_DELETE: begin
				if (del_ok) begin
					rsp_d.status    = ST_OK;
					rsp_d.occupancy = 7'(cnt_q - 1'b1);
				end
			end
			default: begin
				rsp_d.status = ST_NOTFOUND;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			scan_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			scan_s1 <= (state_q == S_SCAN);
			if (scan_s1 && take) begin
				found_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						case (req.req_type)
							REQ_INSERT: state_q <= (beyond_d || cnt_q == FULL_CNT) ?
								S_DONE : S_SCAN;
							REQ_POP:    state_q <= (cnt_q == '0) ? S_DONE : S_SCAN;
							REQ_DELETE: state_q <= (cnt_q == '0) ? S_DONE : S_SCAN;
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_FIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request fields and scan pipeline payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q    <= req;
			beyond_q <= beyond_d;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= idx_q;
			vld_s1 <= valid_q[idx_q];
		end
		if (scan_s1 && take) begin
			best_idx_q <= idx_s1;
			best_q     <= rd_s1;
		end
	end

	// event store
	always_ff @(posedge clk) begin
		if (fire && ins_ok) begin
			mem[best_idx_q] <= wr_entry;
		end
		if (state_q == S_SCAN) begin
			rd_s1 <= mem[idx_q];
		end
	end

	// queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
			seq_q   <= '0;
			cur_q   <= '0;
		end else if (fire) begin
			if (ins_ok) begin
				valid_q[best_idx_q] <= 1'b1;
				cnt_q               <= cnt_q + 1'b1;
				seq_q               <= seq_q + 32'd1;
			end
			if (pop_ok || del_ok) begin
				valid_q[best_idx_q] <= 1'b0;
				cnt_q               <= cnt_q - 1'b1;
			end
			if (adv_time) begin
				cur_q <= best_q.ev_time;
			end
		end
	end

	// end time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q <= '0;
		end else if (cfg_we) begin
			end_q <= cfg_wdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	// occupancy count tracks the valid bits
	a_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CW'($countones(valid_q)))
		else $error("occupancy count differs from valid bits");

	// never more events than slots
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("occupancy above queue depth");

	// a new response only comes out of the completion state
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("response raised outside completion");

	// current time never lags a popped event
	a_time_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.now_time >= rsp_q.out_time)
		else $error("current time behind popped event");

	// a scan finishes before the response is built
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> !scan_s1 && state_q == S_DONE)
		else $error("scan still running at completion");

endmodule

`default_nettype wire

>>> sim/event_queue_checker.sv
`timescale 1ns / 100ps

module event_queue_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic  [63:0]   cfg_wdata,
	input  wire logic           req_valid,
	input  wire logic           req_stall,
	input  wire tep_pkg::req_t  req,
	input  wire logic           rsp_valid,
	input  wire logic           rsp_stall,
	input  wire tep_pkg::rsp_t  rsp,
	output int                  errors,
	output int                  pending
);

	import tep_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;

	// shadow copy of the event store
	logic        held         [DEPTH];
	logic [63:0] held_time    [DEPTH];
	logic [2:0]  held_class   [DEPTH];
	logic [31:0] held_id      [DEPTH];
	logic [31:0] held_payload [DEPTH];
	logic [31:0] next_id;
	logic [63:0] sim_now;
	logic [63:0] end_time;

	// responses owed by the block, oldest first
	rsp_t expected_rsps[$];
	rsp_t oldest;

	// apply one request to the shadow store and return its response
	function automatic rsp_t queue_outcome(input req_t r);
		rsp_t o;
		int   pick;
		int   count;
		o        = '0;
		o.status = ST_NOTFOUND;
		pick     = -1;
		count    = 0;
		case (r.req_type)
			REQ_INSERT: begin
				// callbacks past a set end time are refused before the full check
				if (r.event_class == CLASS_CALLBACK && end_time != 0 &&
						r.event_time > end_time) begin
					o.status = ST_BEYOND;
				end else begin
					for (int i = DEPTH - 1; i >= 0; i--)
						if (!held[i])
							pick = i;
					if (pick < 0) begin
						o.status = ST_FULL;
					end else begin
						held[pick]         = 1'b1;
						held_time[pick]    = r.event_time;
						held_class[pick]   = r.event_class;
						held_id[pick]      = next_id;
						held_payload[pick] = r.event_payload;
						o.assigned_id      = next_id;
						next_id            = next_id + 32'd1;
						o.status           = ST_OK;
					end
				end
			end
			REQ_POP: begin
				// least key: time, then class, then id
				for (int i = 0; i < DEPTH; i++)
					if (held[i] && (pick < 0 ||
							{held_time[i], held_class[i], held_id[i]} <
							{held_time[pick], held_class[pick], held_id[pick]}))
						pick = i;
				if (pick < 0) begin
					o.status = ST_EMPTY;
				end else begin
					held[pick]    = 1'b0;
					o.out_time    = held_time[pick];
					o.out_class   = held_class[pick];
					o.out_payload = held_payload[pick];
					o.out_id      = held_id[pick];
					if (held_time[pick] > sim_now)
						sim_now = held_time[pick];
					o.status = ST_OK;
				end
			end
			REQ_DELETE: begin
				// lowest slot with a matching id, deletable only inside (now, end)
				for (int i = DEPTH - 1; i >= 0; i--)
					if (held[i] && held_id[i] == r.target_id)
						pick = i;
				if (pick >= 0 && held_time[pick] > sim_now && held_time[pick] < end_time) begin
					held[pick] = 1'b0;
					o.status   = ST_OK;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < DEPTH; i++)
			if (held[i])
				count++;
		o.now_time  = sim_now;
		o.occupancy = 7'(count);
		return o;
	endfunction

	task automatic note_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	// track config, predict on each request, compare on each response
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				held[i] = 1'b0;
			next_id  = '0;
			sim_now  = '0;
			end_time = '0;
			expected_rsps.delete();
			pending = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					errors++;
					$display("%0t: response expected none actual %h", $time, rsp);
				end else begin
					oldest = expected_rsps.pop_front();
					note_field("status", 64'(oldest.status), 64'(rsp.status));
					note_field("assigned_id", 64'(oldest.assigned_id), 64'(rsp.assigned_id));
					note_field("out_time", oldest.out_time, rsp.out_time);
					note_field("out_class", 64'(oldest.out_class), 64'(rsp.out_class));
					note_field("out_payload", 64'(oldest.out_payload), 64'(rsp.out_payload));
					note_field("out_id", 64'(oldest.out_id), 64'(rsp.out_id));
					note_field("now_time", oldest.now_time, rsp.now_time);
					note_field("occupancy", 64'(oldest.occupancy), 64'(rsp.occupancy));
				end
			end
			if (cfg_we)
				end_time = cfg_wdata;
			if (req_valid && !req_stall)
				expected_rsps.push_back(queue_outcome(req));
			pending = expected_rsps.size();
		end
	end

endmodule

>>> sim/timed_event_priority_queue_test.sv
`timescale 1ns / 100ps

module timed_event_priority_queue_test;

	import tep_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_ITEMS = 320;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	int          errors;
	int          pending;

	// stimulus knobs
	int          send_gap_pct = 0;
	int          stall_pct = 0;
	bit          hold_req = 1'b0;
	bit          hold_seen = 1'b0;
	int          hold_left = 0;
	logic [63:0] time_base = 64'd200;
	logic [31:0] insert_count = '0;

	timed_event_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	event_queue_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// response side: random stall, or a long hold when asked
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= (stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
		end
	end

	// give up when no request or response moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	function automatic req_t make_req(input logic [1:0] kind, input logic [63:0] t,
			input logic [2:0] cls, input logic [31:0] payload, input logic [31:0] target);
		req_t r;
		r.req_type      = kind;
		r.event_time    = t;
		r.event_class   = cls;
		r.event_payload = payload;
		r.target_id     = target;
		return r;
	endfunction

	// offer one request, called and returning at a falling edge
	task automatic send_request(input req_t r);
		while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// end time changes only with nothing outstanding
	task automatic write_end_time(input logic [63:0] value);
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_idling(input idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin
				send_gap_pct = 0;
				stall_pct    = 0;
			end
			IDLE_SENDER: begin
				send_gap_pct = 48;
				stall_pct    = 0;
			end
			IDLE_RECEIVER: begin
				send_gap_pct = 0;
				stall_pct    = 48;
			end
			default: begin
				send_gap_pct = 19;
				stall_pct    = 19;
			end
		endcase
	endtask

	// bursts that lean toward filling, draining or holding the store level
	task automatic run_random(input int count, input bit wide_times);
		int   burst_left;
		int   roll;
		int   insert_pct;
		int   pop_pct;
		mix_e mix;
		req_t r;
		burst_left = 0;
		mix        = MIX_EVEN;
		for (int n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(16, 64);
				mix        = mix_e'($urandom_range(0, 2));
			end
			burst_left--;
			case (mix)
				MIX_FILL: begin
					insert_pct = 85;
					pop_pct    = 5;
				end
				MIX_DRAIN: begin
					insert_pct = 10;
					pop_pct    = 75;
				end
				default: begin
					insert_pct = 40;
					pop_pct    = 35;
				end
			endcase
			r.event_payload = $urandom;
			r.event_class   = 3'($urandom_range(0, 7));
			if ($urandom_range(0, 3) == 0)
				r.event_class = CLASS_CALLBACK;
			r.event_time = time_base + 64'($urandom_range(0, 300));
			if (wide_times) begin
				case ($urandom_range(0, 3))
					0: r.event_time = {$urandom, $urandom};
					1: r.event_time = '1;
					2: r.event_time = '0;
					default: ;
				endcase
			end
			// mostly aim deletes at recently issued ids
			if (insert_count != 0 && $urandom_range(0, 3) != 0)
				r.target_id = insert_count - 32'($urandom_range(1, 70));
			else
				r.target_id = $urandom;
			roll = $urandom_range(0, 99);
			if (roll >= 97)
				r.req_type = REQ_UNUSED;
			else if (roll < insert_pct)
				r.req_type = REQ_INSERT;
			else if (roll < insert_pct + pop_pct)
				r.req_type = REQ_POP;
			else
				r.req_type = REQ_DELETE;
			if (r.req_type == REQ_INSERT)
				insert_count++;
			time_base = time_base + 64'($urandom_range(0, 1));
			send_request(r);
		end
	endtask

	// main sequence
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty store, unused code, tie order, no end set
		send_request(make_req(REQ_POP, 64'd0, 3'd0, 32'd0, 32'd0));
		send_request(make_req(REQ_DELETE, 64'd0, 3'd0, 32'd0, 32'd0));
		send_request(make_req(REQ_UNUSED, '1, 3'd7, '1, '1));
		send_request(make_req(REQ_INSERT, 64'd5, CLASS_CALLBACK, '1, 32'd0));
		send_request(make_req(REQ_INSERT, 64'd5, 3'd0, 32'd0, 32'd0));
		send_request(make_req(REQ_INSERT, 64'd5, 3'd0, 32'h5a5a_a5a5, 32'd0));
		send_request(make_req(REQ_DELETE, 64'd0, 3'd0, 32'd0, 32'd1));
		send_request(make_req(REQ_POP, 64'd0, 3'd0, 32'd0, 32'd0));
		send_request(make_req(REQ_POP, 64'd0, 3'd0, 32'd0, 32'd0));
		send_request(make_req(REQ_POP, 64'd0, 3'd0, 32'd0, 32'd0));
		send_request(make_req(REQ_POP, 64'd0, 3'd0, 32'd0, 32'd0));

		// directed: callback past end, delete window edges, pop behind now
		write_end_time(64'd100);
		send_request(make_req(REQ_INSERT, 64'd101, CLASS_CALLBACK, 32'd1, 32'd0));
		send_request(make_req(REQ_INSERT, 64'd100, CLASS_CALLBACK, 32'd2, 32'd0));
		send_request(make_req(REQ_INSERT, 64'd50, 3'd3, 32'd3, 32'd0));
		send_request(make_req(REQ_DELETE, 64'd0, 3'd0, 32'd0, 32'd4));
		send_request(make_req(REQ_DELETE, 64'd0, 3'd0, 32'd0, 32'd3));
		send_request(make_req(REQ_DELETE, 64'd0, 3'd0, 32'd0, 32'd4));
		send_request(make_req(REQ_INSERT, 64'd3, 3'd1, 32'd4, 32'd0));
		send_request(make_req(REQ_DELETE, 64'd0, 3'd0, 32'd0, 32'd5));
		send_request(make_req(REQ_POP, 64'd0, 3'd0, 32'd0, 32'd0));
		send_request(make_req(REQ_POP, 64'd0, 3'd0, 32'd0, 32'd0));
		insert_count = 32'd6;

		// random phases with different end times and idling
		write_end_time(time_base + 64'd400);
		set_idling(IDLE_NONE);
		run_random(PHASE_ITEMS, 1'b0);

		write_end_time('1);
		set_idling(IDLE_SENDER);
		run_random(PHASE_ITEMS, 1'b0);

		// long receiver hold while requests keep coming
		write_end_time(time_base + 64'd300);
		set_idling(IDLE_RECEIVER);
		hold_req = ~hold_req;
		run_random(PHASE_ITEMS, 1'b0);

		write_end_time('0);
		set_idling(IDLE_BOTH);
		run_random(PHASE_ITEMS, 1'b0);

		write_end_time(time_base + 64'd400);
		set_idling(IDLE_NONE);
		run_random(PHASE_ITEMS, 1'b0);

		// full-range times last, since they push the current time far ahead
		write_end_time({$urandom, $urandom});
		set_idling(IDLE_BOTH);
		run_random(PHASE_ITEMS, 1'b1);

		// drain and let the block settle
		req_valid <= 1'b0;
		set_idling(IDLE_NONE);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/tep_pkg.sv
hw/rtl/timed_event_priority_queue.sv
sim/event_queue_checker.sv
sim/timed_event_priority_queue_test.sv
